// File: rtl/dual_motor_command_drive_unit_assert.svh
// Assertion macros for the dual motor command drive unit.
// Used by dual_motor_command_drive_unit; expects clk and rst_n in scope.
`ifndef DUAL_MOTOR_COMMAND_DRIVE_UNIT_ASSERT_SVH
`define DUAL_MOTOR_COMMAND_DRIVE_UNIT_ASSERT_SVH

// same-cycle implication
`define DMCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmcd assertion failed: same-cycle implication");

// next-cycle implication
`define DMCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmcd assertion failed: next-cycle implication");

`endif

// File: rtl/dmcd_pkg.sv
// Types and constants of the dual motor command drive unit.
// No dependencies; used by the channel interfaces and the top level.
package dmcd_pkg;

    typedef logic [2:0] opcode_t;
    typedef logic [2:0] mode_t;
    typedef logic [3:0] pins_t;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam opcode_t OP_FWD    = 3'd0;
    localparam opcode_t OP_BACK   = 3'd1;
    localparam opcode_t OP_STOP   = 3'd2;
    localparam opcode_t OP_FASTER = 3'd3;
    localparam opcode_t OP_SLOWER = 3'd4;
    localparam opcode_t OP_LEFT   = 3'd5;
    localparam opcode_t OP_RIGHT  = 3'd6;
    localparam opcode_t OP_NOP    = 3'd7;

    localparam mode_t MODE_STOP  = 3'd0;
    localparam mode_t MODE_FWD   = 3'd1;
    localparam mode_t MODE_BACK  = 3'd2;
    localparam mode_t MODE_LEFT  = 3'd3;
    localparam mode_t MODE_RIGHT = 3'd4;

    // bit3 A fwd, bit2 A rev, bit1 B fwd, bit0 B rev
    localparam pins_t PINS_STOP  = 4'h0;
    localparam pins_t PINS_FWD   = 4'hA;
    localparam pins_t PINS_BACK  = 4'h5;
    localparam pins_t PINS_LEFT  = 4'h9;
    localparam pins_t PINS_RIGHT = 4'h6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP    = 3'd4;

    localparam logic [15:0] LONG_TIMEOUT_RST  = 16'd2000;
    localparam logic [15:0] SHORT_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  LOWEST_SPEED_RST  = 8'd100;
    localparam logic [7:0]  HIGHEST_SPEED_RST = 8'd255;
    localparam logic [7:0]  SPEED_STEP_RST    = 8'd25;

endpackage

// File: rtl/dmcd_in_if.sv
// Request channel of the dual motor command drive unit: ticks and commands.
// Depends on dmcd_pkg for the opcode type.
interface dmcd_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    dmcd_pkg::opcode_t  opcode;
    logic [15:0]        elapsed_ms;

    modport source (output valid, kind, opcode, elapsed_ms, input ready);
    modport sink (input valid, kind, opcode, elapsed_ms, output ready);
endinterface

// File: rtl/dmcd_out_if.sv
// Result channel of the dual motor command drive unit: bridge pins, duty, mode.
// Depends on dmcd_pkg for the mode type.
interface dmcd_out_if;
    logic             valid;
    logic             ready;
    logic [1:0]       bridge_a;
    logic [1:0]       bridge_b;
    logic [7:0]       duty_a;
    logic [7:0]       duty_b;
    dmcd_pkg::mode_t  drive_mode;

    modport source (output valid, bridge_a, bridge_b, duty_a, duty_b, drive_mode,
                    input ready);
    modport sink (input valid, bridge_a, bridge_b, duty_a, duty_b, drive_mode,
                  output ready);
endinterface

// File: rtl/dual_motor_command_drive_unit.sv
// Dual motor command drive unit: top level.
// Result: registered, and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the state registers double as the result
// register, so a new request is taken whenever the result is free or being taken.
// Reset (rst_n low, asynchronous): configuration to defaults, drive stopped,
// timers loaded from the default timeouts, speed at the lowest default.
module dual_motor_command_drive_unit #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dmcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dmcd_pkg::CFG_DATA_W-1:0]        cfg_data,
    dmcd_in_if.sink                                cmd,
    dmcd_out_if.source                             res
);
    import dmcd_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [CMP_W-1:0] TMAX_EXT = CMP_W'({TIMER_WIDTH{1'b1}});
    localparam logic [CMP_W-1:0] LONG_RST_EXT  = CMP_W'(LONG_TIMEOUT_RST);
    localparam logic [CMP_W-1:0] SHORT_RST_EXT = CMP_W'(SHORT_TIMEOUT_RST);
    localparam logic [TIMER_WIDTH-1:0] LONG_TIMER_RST =
        (LONG_RST_EXT > TMAX_EXT) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(LONG_RST_EXT);
    localparam logic [TIMER_WIDTH-1:0] SHORT_TIMER_RST =
        (SHORT_RST_EXT > TMAX_EXT) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(SHORT_RST_EXT);

    logic [15:0] long_timeout_reg;
    logic [15:0] short_timeout_reg;
    logic [7:0]  lowest_speed_reg;
    logic [7:0]  highest_speed_reg;
    logic [7:0]  speed_step_reg;

    logic [TIMER_WIDTH-1:0] long_timer_reg, long_timer_next;
    logic [TIMER_WIDTH-1:0] short_timer_reg, short_timer_next;
    logic [7:0]             speed_reg, speed_next;
    mode_t                  mode_reg, mode_next;
    pins_t                  pins_reg, pins_next;
    logic [7:0]             duty_reg, duty_next;
    logic                   valid_reg;

    logic                   accept;
    logic [CMP_W-1:0]       long_cfg_ext, short_cfg_ext, elapsed_ext;
    logic [CMP_W-1:0]       long_cur_ext, short_cur_ext;
    logic [TIMER_WIDTH-1:0] long_load, short_load;
    logic [TIMER_WIDTH-1:0] long_dec, short_dec;
    logic [8:0]             up_sum;
    logic [7:0]             speed_up, speed_down;
    logic signed [9:0]      dn_diff;

    assign cmd.ready = !valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_timeout_reg  <= LONG_TIMEOUT_RST;
            short_timeout_reg <= SHORT_TIMEOUT_RST;
            lowest_speed_reg  <= LOWEST_SPEED_RST;
            highest_speed_reg <= HIGHEST_SPEED_RST;
            speed_step_reg    <= SPEED_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_TIMEOUT:  long_timeout_reg  <= cfg_data;
                CFG_SHORT_TIMEOUT: short_timeout_reg <= cfg_data;
                CFG_LOWEST_SPEED:  lowest_speed_reg  <= cfg_data[7:0];
                CFG_HIGHEST_SPEED: highest_speed_reg <= cfg_data[7:0];
                CFG_SPEED_STEP:    speed_step_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // timer reload (saturate to timer range) and floored decrement
    always_comb
    begin
        long_cfg_ext  = CMP_W'(long_timeout_reg);
        short_cfg_ext = CMP_W'(short_timeout_reg);
        elapsed_ext   = CMP_W'(cmd.elapsed_ms);
        long_cur_ext  = CMP_W'(long_timer_reg);
        short_cur_ext = CMP_W'(short_timer_reg);
        long_load  = (long_cfg_ext > TMAX_EXT) ? {TIMER_WIDTH{1'b1}}
                                               : TIMER_WIDTH'(long_cfg_ext);
        short_load = (short_cfg_ext > TMAX_EXT) ? {TIMER_WIDTH{1'b1}}
                                                : TIMER_WIDTH'(short_cfg_ext);
        long_dec  = (elapsed_ext >= long_cur_ext) ? '0
                                                  : TIMER_WIDTH'(long_cur_ext - elapsed_ext);
        short_dec = (elapsed_ext >= short_cur_ext) ? '0
                                                   : TIMER_WIDTH'(short_cur_ext - elapsed_ext);
    end

    // speed clamps
    always_comb
    begin
        up_sum   = {1'b0, speed_reg} + {1'b0, speed_step_reg};
        speed_up = (up_sum > {1'b0, highest_speed_reg}) ? highest_speed_reg : up_sum[7:0];
        dn_diff  = $signed({2'b00, speed_reg}) - $signed({2'b00, speed_step_reg});
        speed_down = (dn_diff < $signed({2'b00, lowest_speed_reg})) ? lowest_speed_reg
                                                                    : dn_diff[7:0];
    end

    always_comb
    begin
        long_timer_next  = long_timer_reg;
        short_timer_next = short_timer_reg;
        speed_next       = speed_reg;
        mode_next        = mode_reg;
        pins_next        = pins_reg;
        duty_next        = duty_reg;
        if (cmd.kind == KIND_TICK)
        begin
            long_timer_next  = long_dec;
            short_timer_next = short_dec;
            if (long_dec == '0)
            begin
                pins_next       = PINS_STOP;
                duty_next       = '0;
                mode_next       = MODE_STOP;
                long_timer_next = long_load;
            end
            else if (short_dec == '0 && (mode_reg == MODE_LEFT || mode_reg == MODE_RIGHT))
            begin
                pins_next       = PINS_FWD;
                duty_next       = speed_reg;
                mode_next       = MODE_FWD;
                long_timer_next = long_load;
            end
        end
        else
        begin
            unique case (cmd.opcode) inside
                OP_FWD:
                begin
                    pins_next       = PINS_FWD;
                    duty_next       = speed_reg;
                    mode_next       = MODE_FWD;
                    long_timer_next = long_load;
                end
                OP_BACK:
                begin
                    pins_next       = PINS_BACK;
                    duty_next       = speed_reg;
                    mode_next       = MODE_BACK;
                    long_timer_next = long_load;
                end
                OP_STOP:
                begin
                    pins_next       = PINS_STOP;
                    duty_next       = '0;
                    mode_next       = MODE_STOP;
                    long_timer_next = long_load;
                end
                OP_FASTER, OP_SLOWER:
                begin
                    speed_next       = (cmd.opcode == OP_FASTER) ? speed_up : speed_down;
                    duty_next        = speed_next;
                    long_timer_next  = long_load;
                    short_timer_next = short_load;
                end
                OP_LEFT:
                begin
                    pins_next        = PINS_LEFT;
                    duty_next        = speed_reg;
                    mode_next        = MODE_LEFT;
                    long_timer_next  = long_load;
                    short_timer_next = short_load;
                end
                OP_RIGHT:
                begin
                    pins_next        = PINS_RIGHT;
                    duty_next        = speed_reg;
                    mode_next        = MODE_RIGHT;
                    long_timer_next  = long_load;
                    short_timer_next = short_load;
                end
                OP_NOP: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_timer_reg  <= LONG_TIMER_RST;
            short_timer_reg <= SHORT_TIMER_RST;
            speed_reg       <= LOWEST_SPEED_RST;
            mode_reg        <= MODE_STOP;
            pins_reg        <= PINS_STOP;
            duty_reg        <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                long_timer_reg  <= long_timer_next;
                short_timer_reg <= short_timer_next;
                speed_reg       <= speed_next;
                mode_reg        <= mode_next;
                pins_reg        <= pins_next;
                duty_reg        <= duty_next;
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (res.ready)
                valid_reg <= 1'b0;
        end
    end

    assign res.valid      = valid_reg;
    assign res.bridge_a   = pins_reg[3:2];
    assign res.bridge_b   = pins_reg[1:0];
    assign res.duty_a     = duty_reg;
    assign res.duty_b     = duty_reg;
    assign res.drive_mode = mode_reg;

`include "dual_motor_command_drive_unit_assert.svh"

    `DMCD_ASSERT_NXT(a_result_follows_request, accept, res.valid)
    `DMCD_ASSERT_IMP(a_stop_pins_low, mode_reg == MODE_STOP, pins_reg == PINS_STOP)
    `DMCD_ASSERT_IMP(a_left_pins, mode_reg == MODE_LEFT, pins_reg == PINS_LEFT)
    `DMCD_ASSERT_NXT(a_hold_without_request, !accept, $stable(mode_reg) && $stable(duty_reg))

endmodule

// File: tb/tb_dual_motor_command_drive_unit.sv
// Testbench for dual_motor_command_drive_unit: a directed table of requests, then
// random ticks and commands over several register settings, checked by a predictor.
// Depends on dmcd_pkg, dmcd_in_if, dmcd_out_if and the RTL top level.
module tb_dual_motor_command_drive_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dmcd_pkg::*;

    localparam int RANDOM_PER_PHASE = 238;
    localparam int PHASE_COUNT      = 8;
    localparam int DRAIN_CYCLES     = 4;
    localparam int RUN_LIMIT_NS     = 2_000_000;

    typedef struct packed {
        logic [1:0] bridge_a;
        logic [1:0] bridge_b;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        mode_t      drive_mode;
    } drive_result_t;

    typedef struct {
        logic          kind;
        opcode_t       opcode;
        logic [15:0]   elapsed_ms;
        bit            known;
        drive_result_t result;
    } drive_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dmcd_in_if  cmd_if ();
    dmcd_out_if res_if ();

    dual_motor_command_drive_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // register copies
    logic [15:0] long_timeout_cfg;
    logic [15:0] short_timeout_cfg;
    logic [7:0]  lowest_cfg;
    logic [7:0]  highest_cfg;
    logic [7:0]  step_cfg;

    // drive state copy
    logic [15:0] long_left;
    logic [15:0] short_left;
    logic [7:0]  speed_level;
    logic [7:0]  duty_level;
    mode_t       mode_now;
    pins_t       pins_now;

    bit            row_known;
    drive_result_t row_result;
    int            src_idle_pct   = 0;
    int            rcv_stall_pct  = 0;
    int            mismatch_count = 0;
    drive_result_t expected_drive[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic drive_result_t pack_result(pins_t pins, logic [7:0] duty, mode_t mode);
        drive_result_t r;
        r.bridge_a   = pins[3:2];
        r.bridge_b   = pins[1:0];
        r.duty_a     = duty;
        r.duty_b     = duty;
        r.drive_mode = mode;
        return r;
    endfunction

    function automatic logic [15:0] count_down(logic [15:0] t, logic [15:0] d);
        return (d >= t) ? 16'd0 : t - d;
    endfunction

    function automatic void latch_drive(pins_t pins, logic [7:0] duty, mode_t mode);
        pins_now   = pins;
        duty_level = duty;
        mode_now   = mode;
        long_left  = long_timeout_cfg;
    endfunction

    function automatic drive_result_t drive_after_request(logic kind, opcode_t op,
                                                          logic [15:0] el);
        int s;
        if (kind == KIND_TICK)
        begin
            long_left  = count_down(long_left, el);
            short_left = count_down(short_left, el);
            if (long_left == 16'd0)
                latch_drive(PINS_STOP, 8'd0, MODE_STOP);
            else if (short_left == 16'd0 && (mode_now == MODE_LEFT || mode_now == MODE_RIGHT))
                latch_drive(PINS_FWD, speed_level, MODE_FWD);
        end
        else
        begin
            case (op) inside
                OP_FWD:  latch_drive(PINS_FWD, speed_level, MODE_FWD);
                OP_BACK: latch_drive(PINS_BACK, speed_level, MODE_BACK);
                OP_STOP: latch_drive(PINS_STOP, 8'd0, MODE_STOP);
                OP_FASTER, OP_SLOWER:
                begin
                    if (op == OP_FASTER)
                    begin
                        s = int'(speed_level) + int'(step_cfg);
                        if (s > int'(highest_cfg))
                            s = int'(highest_cfg);
                    end
                    else
                    begin
                        s = int'(speed_level) - int'(step_cfg);
                        if (s < int'(lowest_cfg))
                            s = int'(lowest_cfg);
                    end
                    speed_level = 8'(s);
                    latch_drive(pins_now, speed_level, mode_now);
                    short_left = short_timeout_cfg;
                end
                OP_LEFT:
                begin
                    latch_drive(PINS_LEFT, speed_level, MODE_LEFT);
                    short_left = short_timeout_cfg;
                end
                OP_RIGHT:
                begin
                    latch_drive(PINS_RIGHT, speed_level, MODE_RIGHT);
                    short_left = short_timeout_cfg;
                end
                default: ;
            endcase
        end
        return pack_result(pins_now, duty_level, mode_now);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic drive_row_t plain_row(logic kind, opcode_t op, logic [15:0] el);
        drive_row_t row;
        row.kind       = kind;
        row.opcode     = op;
        row.elapsed_ms = el;
        row.known      = 1'b0;
        row.result     = '0;
        return row;
    endfunction

    function automatic drive_row_t known_row(logic kind, opcode_t op, logic [15:0] el,
                                             pins_t pins, logic [7:0] duty, mode_t mode);
        drive_row_t row;
        row        = plain_row(kind, op, el);
        row.known  = 1'b1;
        row.result = pack_result(pins, duty, mode);
        return row;
    endfunction

    task automatic send_request(logic kind, opcode_t op, logic [15:0] el, bit known,
                                drive_result_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.opcode     <= op;
        cmd_if.elapsed_ms <= el;
        row_known         <= known;
        row_result        <= r;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LONG_TIMEOUT:  long_timeout_cfg  = data;
            CFG_SHORT_TIMEOUT: short_timeout_cfg = data;
            CFG_LOWEST_SPEED:  lowest_cfg        = data[7:0];
            CFG_HIGHEST_SPEED: highest_cfg       = data[7:0];
            CFG_SPEED_STEP:    step_cfg          = data[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [15:0] lt, logic [15:0] st, logic [7:0] lo,
                                  logic [7:0] hi, logic [7:0] stp);
        write_reg(CFG_LONG_TIMEOUT, lt);
        write_reg(CFG_SHORT_TIMEOUT, st);
        write_reg(CFG_LOWEST_SPEED, {8'($urandom), lo});
        write_reg(CFG_HIGHEST_SPEED, {8'($urandom), hi});
        write_reg(CFG_SPEED_STEP, {8'($urandom), stp});
        write_reg(CFG_IDX_W'($urandom_range(7, 5)), 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : drive_monitor
        drive_result_t want;
        drive_result_t model;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("drive result with no request pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("bridge_a", 8'(want.bridge_a), 8'(res_if.bridge_a));
                    check_field("bridge_b", 8'(want.bridge_b), 8'(res_if.bridge_b));
                    check_field("duty_a", want.duty_a, res_if.duty_a);
                    check_field("duty_b", want.duty_b, res_if.duty_b);
                    check_field("drive_mode", 8'(want.drive_mode), 8'(res_if.drive_mode));
                end
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                model = drive_after_request(cmd_if.kind, cmd_if.opcode, cmd_if.elapsed_ms);
                expected_drive.push_back(row_known ? row_result : model);
            end
        end
    end

    initial
    begin
        drive_row_t    directed_rows[$];
        drive_result_t blank_result;
        logic          kind;
        opcode_t       op;
        logic [15:0]   el;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = KIND_TICK;
        cmd_if.opcode     = OP_FWD;
        cmd_if.elapsed_ms = '0;
        row_known         = 1'b0;
        row_result        = '0;
        blank_result      = '0;

        long_timeout_cfg  = LONG_TIMEOUT_RST;
        short_timeout_cfg = SHORT_TIMEOUT_RST;
        lowest_cfg        = LOWEST_SPEED_RST;
        highest_cfg       = HIGHEST_SPEED_RST;
        step_cfg          = SPEED_STEP_RST;
        long_left         = LONG_TIMEOUT_RST;
        short_left        = SHORT_TIMEOUT_RST;
        speed_level       = LOWEST_SPEED_RST;
        duty_level        = 8'd0;
        mode_now          = MODE_STOP;
        pins_now          = PINS_STOP;

        directed_rows.push_back(known_row(KIND_TICK, OP_NOP, 16'd0, PINS_STOP, 8'd0, MODE_STOP));
        directed_rows.push_back(known_row(KIND_CMD, OP_NOP, 16'hFFFF, PINS_STOP, 8'd0,
                                          MODE_STOP));
        directed_rows.push_back(known_row(KIND_CMD, OP_FWD, 16'd0, PINS_FWD, LOWEST_SPEED_RST,
                                          MODE_FWD));
        directed_rows.push_back(known_row(KIND_CMD, OP_STOP, 16'h00FF, PINS_STOP, 8'd0,
                                          MODE_STOP));
        // speed change while stopped
        directed_rows.push_back(plain_row(KIND_CMD, OP_FASTER, 16'h5A5A));
        directed_rows.push_back(plain_row(KIND_CMD, OP_FWD, 16'hA5A5));
        repeat (5) directed_rows.push_back(plain_row(KIND_CMD, OP_FASTER, 16'd0));
        directed_rows.push_back(known_row(KIND_CMD, OP_FASTER, 16'd0, PINS_FWD,
                                          HIGHEST_SPEED_RST, MODE_FWD));
        directed_rows.push_back(plain_row(KIND_CMD, OP_SLOWER, 16'd0));
        // turn, then let the short timer run out
        directed_rows.push_back(plain_row(KIND_CMD, OP_LEFT, 16'd0));
        directed_rows.push_back(plain_row(KIND_TICK, OP_FWD, 16'd499));
        directed_rows.push_back(plain_row(KIND_TICK, OP_BACK, 16'd1));
        // watchdog expiry, twice in a row
        directed_rows.push_back(plain_row(KIND_CMD, OP_RIGHT, 16'd0));
        directed_rows.push_back(known_row(KIND_TICK, OP_NOP, 16'hFFFF, PINS_STOP, 8'd0,
                                          MODE_STOP));
        directed_rows.push_back(known_row(KIND_TICK, OP_RIGHT, 16'hFFFF, PINS_STOP, 8'd0,
                                          MODE_STOP));
        directed_rows.push_back(plain_row(KIND_CMD, OP_BACK, 16'hFFFF));
        directed_rows.push_back(plain_row(KIND_TICK, OP_STOP, 16'd0));
        directed_rows.push_back(known_row(KIND_CMD, OP_STOP, 16'd0, PINS_STOP, 8'd0,
                                          MODE_STOP));
        directed_rows.push_back(plain_row(KIND_CMD, OP_SLOWER, 16'd0));

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].opcode,
                         directed_rows[i].elapsed_ms, directed_rows[i].known,
                         directed_rows[i].result);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                case (phase)
                    1: apply_settings(16'd1, 16'd1, 8'd0, 8'd255, 8'd255);
                    2: apply_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'd1);
                    3: apply_settings(16'hFFFF, 16'd1, 8'd0, 8'd0, 8'd1);
                    default: apply_settings(16'($urandom_range(3000, 1)),
                                            16'($urandom_range(1500, 1)),
                                            8'($urandom_range(255)), 8'($urandom_range(255)),
                                            8'($urandom_range(255, 1)));
                endcase
            end
            case (phase % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 49;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 49;
                end
                default:
                begin
                    src_idle_pct  = 21;
                    rcv_stall_pct = 21;
                end
            endcase

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                kind = ($urandom_range(99) < 45) ? KIND_TICK : KIND_CMD;
                op   = opcode_t'($urandom_range(7));
                // bias elapsed time toward the timeouts so both expiries occur
                case ($urandom_range(4))
                    0: el = 16'($urandom_range(3));
                    1: el = 16'($urandom_range(short_timeout_cfg));
                    2: el = 16'($urandom_range(long_timeout_cfg));
                    3: el = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd0;
                    default: el = 16'($urandom);
                endcase
                send_request(kind, op, el, 1'b0, blank_result);
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
